// File: rtl/xpf_pkg.sv
// Shared types, sizes and codes for the XOR parity group encoder.
// No dependencies; every other file imports this package.
package xpf_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int WORD_BYTES  = 8;
    localparam int ROWS        = MAX_PAYLOAD / WORD_BYTES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int WCNT_W      = $clog2(ROWS + 1);
    localparam int BYTE_SH     = $clog2(WORD_BYTES);
    localparam int NB_W        = 4;
    localparam int DEFAULT_GROUP = 4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PDESC = 2'd1;
    localparam logic [1:0] KIND_PWORD = 2'd2;

    localparam logic OP_PAYLOAD = 1'b0;
    localparam logic OP_RESET   = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DESC,
        ST_PDESC,
        ST_PWORD
    } state_t;

    // One byte-lane update: XOR data into the lane's row when wr_en is set.
    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
    } lane_req_t;

    typedef logic [WORD_BYTES-1:0][7:0] lane_bytes_t;

endpackage

// File: rtl/xor_parity_fec_group_encoder.sv
// XOR parity group encoder: payload words XOR into an eight-lane parity store.
// Depends on xpf_pkg, xpf_lane and xpf_merge.
//
// Payload words that are not last are taken one per cycle. A last word holds
// the input while its data descriptor goes to the output register; when it
// closes a group, the input stays held for the parity descriptor and
// ceil(max_length / 8) parity words, read row by row from the byte lanes,
// one per cycle unless the output side stalls. The store clears at once
// through per-row valid bits, so no clearing pass follows reset or a close.
module xor_parity_fec_group_encoder
    import xpf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic [63:0]      s_data_word,
    input  logic [NB_W-1:0]  s_valid_bytes,
    input  logic             s_last_word,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [31:0]      m_seq_number,
    output logic [31:0]      m_group_number,
    output logic [LEN_W-1:0] m_packet_length,
    output logic [LEN_W-1:0] m_length_parity,
    output logic [63:0]      m_parity_word,
    output logic [NB_W-1:0]  m_parity_bytes,
    output logic             m_overflow,
    output logic             m_last
);

    state_t state_reg, state_next;

    logic [7:0]        gsize_reg;
    logic [LEN_W-1:0]  off_reg;
    logic              ovf_seen_reg;
    logic [LEN_W-1:0]  max_reg;
    logic [LEN_W-1:0]  xor_reg;
    logic [7:0]        pkts_reg;
    logic [31:0]       group_reg;
    logic [31:0]       seq_reg;
    logic [LEN_W-1:0]  desc_len_reg;
    logic              desc_ovf_reg;
    logic              close_reg;
    logic [ROW_W-1:0]  idx_reg;

    logic              m_valid_reg;
    logic [1:0]        kind_reg;
    logic [31:0]       seq_out_reg;
    logic [31:0]       grp_out_reg;
    logic [LEN_W-1:0]  len_out_reg;
    logic [LEN_W-1:0]  lpar_out_reg;
    logic [63:0]       word_out_reg;
    logic [NB_W-1:0]   bytes_out_reg;
    logic              ovf_out_reg;
    logic              last_out_reg;

    // ingest
    logic              in_acc;
    logic              acc_payload;
    logic              acc_reset;
    logic [NB_W-1:0]   nb_eff;
    logic [LEN_W:0]    room;
    logic              ovf_now;
    logic [NB_W-1:0]   written;
    logic [LEN_W-1:0]  off_next;
    logic              ovf_any;
    logic [LEN_W-1:0]  max_next;
    logic [7:0]        pkts_next;
    logic [7:0]        limit;

    // drain
    logic [WCNT_W-1:0] words;
    logic              idx_last;
    logic              out_load;
    logic              grp_done;
    logic              lane_clear;
    lane_bytes_t       lane_bytes;
    logic [63:0]       merged_word;
    logic [NB_W-1:0]   merged_cnt;

    // result being loaded
    logic [1:0]        res_kind;
    logic [31:0]       res_seq;
    logic [LEN_W-1:0]  res_len;
    logic [LEN_W-1:0]  res_lpar;
    logic [63:0]       res_word;
    logic [NB_W-1:0]   res_bytes;
    logic              res_ovf;
    logic              res_last;

    lane_req_t         lane_req [WORD_BYTES];

    assign in_acc      = s_valid && s_ready;
    assign acc_payload = in_acc && (s_operation == OP_PAYLOAD);
    assign acc_reset   = in_acc && (s_operation == OP_RESET);

    always_comb begin
        nb_eff    = (s_valid_bytes > NB_W'(WORD_BYTES)) ? NB_W'(WORD_BYTES) : s_valid_bytes;
        room      = (LEN_W+1)'(MAX_PAYLOAD) - {1'b0, off_reg};
        ovf_now   = ({{(LEN_W+1-NB_W){1'b0}}, nb_eff} > room);
        written   = ovf_now ? room[NB_W-1:0] : nb_eff;
        off_next  = off_reg + LEN_W'(written);
        ovf_any   = ovf_seen_reg || ovf_now;
        max_next  = (off_next > max_reg) ? off_next : max_reg;
        pkts_next = pkts_reg + 8'd1;
        limit     = (gsize_reg == 8'd0) ? 8'(DEFAULT_GROUP) : gsize_reg;
    end

    // Each lane owns the store bytes whose offset is congruent to its index.
    for (genvar b = 0; b < WORD_BYTES; b++) begin : g_lane
        logic [BYTE_SH-1:0] k;
        logic [LEN_W:0]     pos;

        always_comb begin
            k   = BYTE_SH'(b) - off_reg[BYTE_SH-1:0];
            pos = {1'b0, off_reg} + (LEN_W+1)'(k);
            lane_req[b].wr_en = acc_payload && (NB_W'(k) < nb_eff)
                                && (pos < (LEN_W+1)'(MAX_PAYLOAD));
            lane_req[b].row   = (state_reg == ST_RUN) ? pos[BYTE_SH +: ROW_W] : idx_reg;
            lane_req[b].data  = s_data_word[8*k +: 8];
        end

        xpf_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (lane_req[b]),
            .clear   (lane_clear),
            .rd_byte (lane_bytes[b])
        );
    end

    xpf_merge u_merge (
        .lane_bytes (lane_bytes),
        .max_len    (max_reg),
        .word_idx   (idx_reg),
        .word       (merged_word),
        .cnt        (merged_cnt)
    );

    always_comb begin
        words    = WCNT_W'(({1'b0, max_reg} + (LEN_W+1)'(WORD_BYTES - 1)) >> BYTE_SH);
        idx_last = ({1'b0, idx_reg} == (words - WCNT_W'(1)));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (acc_payload && s_last_word) begin
                    state_next = ST_DESC;
                end
            end
            ST_DESC: begin
                if (out_load) begin
                    state_next = close_reg ? ST_PDESC : ST_RUN;
                end
            end
            ST_PDESC: begin
                if (out_load) begin
                    state_next = (words == '0) ? ST_RUN : ST_PWORD;
                end
            end
            ST_PWORD: begin
                if (out_load && idx_last) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = (state_reg == ST_RUN);
        out_load  = (state_reg != ST_RUN) && (!m_valid_reg || m_ready);
        grp_done  = 1'b0;
        res_kind  = KIND_DATA;
        res_seq   = '0;
        res_len   = '0;
        res_lpar  = '0;
        res_word  = '0;
        res_bytes = '0;
        res_ovf   = 1'b0;
        res_last  = 1'b0;
        case (state_reg)
            ST_DESC: begin
                res_kind = KIND_DATA;
                res_seq  = seq_reg;
                res_len  = desc_len_reg;
                res_ovf  = desc_ovf_reg;
                res_last = !close_reg;
            end
            ST_PDESC: begin
                res_kind = KIND_PDESC;
                res_seq  = seq_reg;
                res_len  = max_reg;
                res_lpar = xor_reg;
                res_last = (words == '0);
                grp_done = out_load && (words == '0);
            end
            ST_PWORD: begin
                res_kind  = KIND_PWORD;
                res_word  = merged_word;
                res_bytes = merged_cnt;
                res_last  = idx_last;
                grp_done  = out_load && idx_last;
            end
            default: begin
                res_kind = KIND_DATA;
            end
        endcase
    end

    assign lane_clear = acc_reset || grp_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            gsize_reg    <= 8'(DEFAULT_GROUP);
            off_reg      <= '0;
            ovf_seen_reg <= 1'b0;
            max_reg      <= '0;
            xor_reg      <= '0;
            pkts_reg     <= '0;
            group_reg    <= '0;
            seq_reg      <= '0;
            close_reg    <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                gsize_reg <= cfg_wr_data;
            end
            if (acc_reset) begin
                off_reg      <= '0;
                ovf_seen_reg <= 1'b0;
                max_reg      <= '0;
                xor_reg      <= '0;
                pkts_reg     <= '0;
                group_reg    <= '0;
                seq_reg      <= '0;
            end else if (acc_payload) begin
                if (s_last_word) begin
                    off_reg      <= '0;
                    ovf_seen_reg <= 1'b0;
                    max_reg      <= max_next;
                    xor_reg      <= xor_reg ^ off_next;
                    pkts_reg     <= pkts_next;
                    close_reg    <= (pkts_next >= limit);
                end else begin
                    off_reg      <= off_next;
                    ovf_seen_reg <= ovf_any;
                end
            end
            if (out_load && (state_reg == ST_DESC || state_reg == ST_PDESC)) begin
                seq_reg <= seq_reg + 32'd1;
            end
            if (out_load && state_reg == ST_PDESC) begin
                idx_reg <= '0;
            end else if (out_load && state_reg == ST_PWORD) begin
                idx_reg <= idx_reg + ROW_W'(1);
            end
            // close the group: clear its totals and advance
            if (grp_done) begin
                max_reg   <= '0;
                xor_reg   <= '0;
                pkts_reg  <= '0;
                group_reg <= group_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_payload && s_last_word) begin
            desc_len_reg <= off_next;
            desc_ovf_reg <= ovf_any;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg      <= res_kind;
            seq_out_reg   <= res_seq;
            grp_out_reg   <= group_reg;
            len_out_reg   <= res_len;
            lpar_out_reg  <= res_lpar;
            word_out_reg  <= res_word;
            bytes_out_reg <= res_bytes;
            ovf_out_reg   <= res_ovf;
            last_out_reg  <= res_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_seq_number    = seq_out_reg;
    assign m_group_number  = grp_out_reg;
    assign m_packet_length = len_out_reg;
    assign m_length_parity = lpar_out_reg;
    assign m_parity_word   = word_out_reg;
    assign m_parity_bytes  = bytes_out_reg;
    assign m_overflow      = ovf_out_reg;
    assign m_last          = last_out_reg;

`ifndef SYNTHESIS
    a_off_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        off_reg <= LEN_W'(MAX_PAYLOAD))
        else $error("byte offset past capacity");

    a_last_to_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_payload && s_last_word) |=> (state_reg == ST_DESC))
        else $error("last word did not start a data descriptor");

    a_pword_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && state_reg == ST_PWORD) |-> (merged_cnt != '0))
        else $error("parity word with no bytes");

    a_grp_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_done |=> (pkts_reg == '0 && max_reg == '0 && state_reg == ST_RUN))
        else $error("group totals not cleared at close");
`endif

endmodule

// File: rtl/xpf_lane.sv
// One byte lane of the parity store: ROWS bytes with per-row valid bits.
// Depends on xpf_pkg for sizes and the lane request struct.
module xpf_lane
    import xpf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lane_req_t req,
    input  logic      clear,
    output logic [7:0] rd_byte
);

    logic [7:0]      mem_reg [ROWS];
    logic [ROWS-1:0] vld_reg;

    // A row that was never written since the last clear reads as zero.
    assign rd_byte = vld_reg[req.row] ? mem_reg[req.row] : 8'h00;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.row] <= rd_byte ^ req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (clear) begin
            vld_reg <= '0;
        end else if (req.wr_en) begin
            vld_reg[req.row] <= 1'b1;
        end
    end

endmodule

// File: rtl/xpf_merge.sv
// Merges the lane bytes of one store row into a parity word and its byte count.
// Depends on xpf_pkg for sizes and the lane byte array type.
module xpf_merge
    import xpf_pkg::*;
(
    input  lane_bytes_t        lane_bytes,
    input  logic [LEN_W-1:0]   max_len,
    input  logic [ROW_W-1:0]   word_idx,
    output logic [63:0]        word,
    output logic [NB_W-1:0]    cnt
);

    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] rem;

    always_comb begin
        base = LEN_W'(word_idx) << BYTE_SH;
        rem  = max_len - base;
        if (rem > LEN_W'(WORD_BYTES)) begin
            cnt = NB_W'(WORD_BYTES);
        end else begin
            cnt = rem[NB_W-1:0];
        end
        word = '0;
        for (int b = 0; b < WORD_BYTES; b++) begin
            // drop bytes past the group's longest packet
            if (NB_W'(b) < cnt) begin
                word[8*b +: 8] = lane_bytes[b];
            end
        end
    end

endmodule
